// ----- src/i2caps_pkg.sv -----
// Shared types and constants for the I2C address probe scanner.
package i2caps_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_PROBE = 2'd1;
    localparam logic [1:0] CMD_SCAN  = 2'd2;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_ACK     = 3'd1;
    localparam logic [2:0] EV_NACK    = 3'd2;
    localparam logic [2:0] EV_DONE    = 3'd3;
    localparam logic [2:0] EV_UNAVAIL = 3'd4;

    localparam logic [1:0] REG_BUS_ENABLED = 2'd0;
    localparam logic [1:0] REG_SCAN_FIRST  = 2'd1;
    localparam logic [1:0] REG_SCAN_LAST   = 2'd2;

    localparam logic [5:0] PH_IDLE       = 6'd0;
    localparam logic [5:0] PH_FIRST      = 6'd1;
    localparam logic [5:0] PH_START      = 6'd2;
    localparam logic [5:0] PH_DATA_FIRST = 6'd3;
    localparam logic [5:0] PH_DATA_LAST  = 6'd18;
    localparam logic [5:0] PH_ACK_LOW    = 6'd19;
    localparam logic [5:0] PH_ACK_HIGH   = 6'd20;
    localparam logic [5:0] PH_ACK_SAMPLE = 6'd21;
    localparam logic [5:0] PH_STOP_LOW   = 6'd22;
    localparam logic [5:0] PH_STOP       = 6'd23;
    localparam logic [5:0] PH_DONE       = 6'd24;

    localparam logic [6:0] SCAN_FIRST_RST = 7'd1;
    localparam logic [6:0] SCAN_LAST_RST  = 7'd126;
    localparam logic [7:0] FOUND_MAX      = 8'd255;

    typedef struct packed {
        logic       bus_enabled;
        logic [6:0] scan_first_address;
        logic [6:0] scan_last_address;
    } t_cfg;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] probe_address;
        logic       sda_level;
    } t_in_item;

    typedef struct packed {
        logic       sda_release;
        logic       scl_release;
        logic       busy_res;
        logic [2:0] event_res;
        logic [6:0] event_address;
        logic [7:0] found_count;
        logic       last;
    } t_out_item;

endpackage

// ----- src/i2caps_if.sv -----
// Valid/ready channel interfaces for the scanner's tick input and result output.
interface i2caps_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [6:0] probe_address;
    logic       sda_level;

    modport source(output valid, output cmd, output probe_address, output sda_level,
                   input ready);
    modport sink(input valid, input cmd, input probe_address, input sda_level,
                 output ready);
endinterface

interface i2caps_out_if;
    logic       valid;
    logic       ready;
    logic       sda_release;
    logic       scl_release;
    logic       busy_res;
    logic [2:0] event_res;
    logic [6:0] event_address;
    logic [7:0] found_count;
    logic       last;

    modport source(output valid, output sda_release, output scl_release,
                   output busy_res, output event_res, output event_address,
                   output found_count, output last, input ready);
    modport sink(input valid, input sda_release, input scl_release,
                 input busy_res, input event_res, input event_address,
                 input found_count, input last, output ready);
endinterface

// ----- src/i2caps_core.sv -----
// Probe sequencer: bus phase state and the per-tick result logic.
module i2caps_core
    import i2caps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [5:0] r_phase, n_phase;
    logic [7:0] r_shift, n_shift;
    logic [6:0] r_cur, n_cur;
    logic       r_scanning, n_scanning;
    logic       r_ack, n_ack;
    logic [7:0] r_found, n_found;
    logic       r_sda, n_sda;
    logic       r_scl, n_scl;

    always_comb begin
        n_phase    = r_phase;
        n_shift    = r_shift;
        n_cur      = r_cur;
        n_scanning = r_scanning;
        n_ack      = r_ack;
        n_found    = r_found;
        n_sda      = r_sda;
        n_scl      = r_scl;
        o_result   = '0;

        if (r_phase == PH_IDLE) begin
            if (i_item.cmd == CMD_PROBE || i_item.cmd == CMD_SCAN) begin
                if (!i_cfg.bus_enabled) begin
                    o_result.event_res = EV_UNAVAIL;
                    o_result.event_address =
                        (i_item.cmd == CMD_PROBE) ? i_item.probe_address : 7'd0;
                    o_result.last = 1'b1;
                end else if (i_item.cmd == CMD_SCAN &&
                             i_cfg.scan_first_address > i_cfg.scan_last_address) begin
                    n_scanning = 1'b0;
                    n_found = '0;
                    o_result.event_res = EV_DONE;
                    o_result.last = 1'b1;
                end else begin
                    // The first phase of a new probe runs in the same tick.
                    if (i_item.cmd == CMD_SCAN) begin
                        n_scanning = 1'b1;
                        n_found = '0;
                        n_cur = i_cfg.scan_first_address;
                    end else begin
                        n_scanning = 1'b0;
                        n_cur = i_item.probe_address;
                    end
                    n_shift = {n_cur, 1'b0};
                    n_ack = 1'b0;
                    n_phase = PH_START;
                    n_sda = 1'b1;
                    n_scl = 1'b1;
                    o_result.busy_res = 1'b1;
                end
            end
        end else begin
            o_result.busy_res = 1'b1;
            n_phase = r_phase + 6'd1;
            if (r_phase == PH_FIRST) begin
                n_sda = 1'b1;
                n_scl = 1'b1;
            end else if (r_phase == PH_START) begin
                n_sda = 1'b0;
                n_scl = 1'b1;
            end else if (r_phase >= PH_DATA_FIRST && r_phase <= PH_DATA_LAST) begin
                n_sda = r_shift[7];
                n_scl = ~r_phase[0];
                if (!r_phase[0]) begin
                    n_shift = {r_shift[6:0], 1'b0};
                end
            end else if (r_phase == PH_ACK_LOW) begin
                n_sda = 1'b1;
                n_scl = 1'b0;
            end else if (r_phase == PH_ACK_HIGH) begin
                n_sda = 1'b1;
                n_scl = 1'b1;
            end else if (r_phase == PH_ACK_SAMPLE) begin
                n_ack = ~i_item.sda_level;
                n_sda = 1'b0;
                n_scl = 1'b0;
            end else if (r_phase == PH_STOP_LOW) begin
                n_sda = 1'b0;
                n_scl = 1'b1;
            end else if (r_phase == PH_STOP) begin
                n_sda = 1'b1;
                n_scl = 1'b1;
                if (r_scanning) begin
                    if (r_ack) begin
                        n_found = (r_found == FOUND_MAX) ? r_found : r_found + 8'd1;
                        o_result.event_res = EV_ACK;
                        o_result.event_address = r_cur;
                    end
                    o_result.found_count = n_found;
                    if (r_cur >= i_cfg.scan_last_address) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_cur = r_cur + 7'd1;
                        n_shift = {n_cur, 1'b0};
                        n_ack = 1'b0;
                        n_phase = PH_FIRST;
                    end
                end else begin
                    o_result.event_res = r_ack ? EV_ACK : EV_NACK;
                    o_result.event_address = r_cur;
                    o_result.last = 1'b1;
                    n_phase = PH_IDLE;
                end
            end else begin
                n_sda = 1'b1;
                n_scl = 1'b1;
                if (r_scanning) begin
                    o_result.event_res = EV_DONE;
                    o_result.found_count = r_found;
                    o_result.last = 1'b1;
                end
                n_scanning = 1'b0;
                n_phase = PH_IDLE;
            end
        end

        o_result.sda_release = n_sda;
        o_result.scl_release = n_scl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_shift    <= '0;
            r_cur      <= '0;
            r_scanning <= 1'b0;
            r_ack      <= 1'b0;
            r_found    <= '0;
            r_sda      <= 1'b1;
            r_scl      <= 1'b1;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_shift    <= n_shift;
            r_cur      <= n_cur;
            r_scanning <= n_scanning;
            r_ack      <= n_ack;
            r_found    <= n_found;
            r_sda      <= n_sda;
            r_scl      <= n_scl;
        end
    end

`ifndef SYNTHESIS
    a_idle_not_scanning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> !r_scanning)
        else $error("Scan flag set while the sequencer is idle.");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_DONE)
        else $error("Sequencer phase out of range.");

    a_probe_event_at_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (o_result.event_res == EV_ACK || o_result.event_res == EV_NACK))
        |-> (r_phase == PH_STOP))
        else $error("Probe event reported outside the stop phase.");

    a_single_probe_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_STOP && !r_scanning) |=> (r_phase == PH_IDLE))
        else $error("Single probe did not return to idle after its stop.");
`endif

endmodule

// ----- src/i2c_address_probe_scanner_unit.sv -----
// Top level of the I2C address probe scanner: channels, register port and result register.
//
//  Port group   Direction  Transfer
//  i_in         sink       one half-clock tick: cmd, probe_address, sda_level
//  o_out        source     one result per tick: line releases, busy, event, count, last
//  APB (psel..) slave      reads and writes of bus_enabled, scan_first_address, scan_last_address
//
// Each tick is handled combinationally: the sequencer's next-state logic sits between
// its state registers and the result register, so one transfer is taken per cycle
// while o_out is not stalled. Reset is synchronous and active low; it idles the
// sequencer with both lines released and loads the register defaults. While a result
// waits on o_out, a new tick is taken only in the cycle in which that result is taken.
module i2c_address_probe_scanner_unit
    import i2caps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    i2caps_in_if.sink             i_in,
    i2caps_out_if.source          o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg      r_cfg;
    t_in_item  w_item;
    t_out_item w_result;
    t_out_item r_out;
    logic      r_out_valid;
    logic      w_step;
    logic      w_in_ready;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bus_enabled        <= 1'b0;
            r_cfg.scan_first_address <= SCAN_FIRST_RST;
            r_cfg.scan_last_address  <= SCAN_LAST_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_BUS_ENABLED: r_cfg.bus_enabled        <= pwdata[0];
                REG_SCAN_FIRST:  r_cfg.scan_first_address <= pwdata[6:0];
                REG_SCAN_LAST:   r_cfg.scan_last_address  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BUS_ENABLED: prdata = {31'd0, r_cfg.bus_enabled};
            REG_SCAN_FIRST:  prdata = {25'd0, r_cfg.scan_first_address};
            REG_SCAN_LAST:   prdata = {25'd0, r_cfg.scan_last_address};
            default:         prdata = '0;
        endcase
    end

    assign w_in_ready = !r_out_valid || o_out.ready;
    assign i_in.ready = w_in_ready;
    assign w_step     = i_in.valid && w_in_ready;

    assign w_item.cmd           = i_in.cmd;
    assign w_item.probe_address = i_in.probe_address;
    assign w_item.sda_level     = i_in.sda_level;

    i2caps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (w_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.sda_release   = r_out.sda_release;
    assign o_out.scl_release   = r_out.scl_release;
    assign o_out.busy_res      = r_out.busy_res;
    assign o_out.event_res     = r_out.event_res;
    assign o_out.event_address = r_out.event_address;
    assign o_out.found_count   = r_out.found_count;
    assign o_out.last          = r_out.last;

endmodule
